>>> rtl/servo_position_ramp_assert.svh
// Assertion macros used by the servo position ramp RTL.
`ifndef SERVO_POSITION_RAMP_ASSERT_SVH
`define SERVO_POSITION_RAMP_ASSERT_SVH

// Assert a property on the rising clock, switched off while reset is held.
`define SPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that one condition implies another on the following clock edge.
`define SPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/spr_pkg.sv
// Types and constants of the servo position ramp.
`default_nettype none

package spr_pkg;

  localparam int unsigned AngleW   = 8;
  localparam int unsigned DelayW   = 16;
  localparam int unsigned DivW     = 16;
  localparam int unsigned DivCntW  = 4;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] REG_MAX_STEP    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_INC_DELAY   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DEFAULT_POS = 2'd2;

  localparam logic [AngleW-1:0] RST_MAX_STEP    = 8'd1;
  localparam logic [DelayW-1:0] RST_INC_DELAY   = 16'd20;
  localparam logic [AngleW-1:0] RST_DEFAULT_POS = 8'd90;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_GOTO = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  // What the sequencer does with the divider result.
  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_COUNT,
    JOB_POINT
  } job_e;

endpackage

`default_nettype wire

>>> rtl/servo_position_ramp.sv
// Servo position ramp: slew-rate limited angle generator with a shared divider.
//
// Usage: the input stream carries one word per item. tuser selects the kind:
// a one-millisecond tick or a goto command whose target angle is in tdata.
// Every accepted word produces exactly one output word holding the commanded
// angle, a flag that the angle was just updated, the ramp-in-progress flag and
// a flag that a goto was refused because a ramp was already running.
// Arithmetic: all division runs through one restoring divider that retires one
// quotient bit per cycle. A goto taken while idle runs a division; a tick that
// fires during a ramp runs a multiply and then a division; a tick that does not
// move the servo or a refused goto goes straight to the result stage. The input
// is not ready while an item is being worked on, so no new item is taken until
// the result of the last one has been moved into the output register.
// The output word sits in its own register, so the next item is taken while
// a finished word still waits; if the receiver stalls, the following item
// finishes its arithmetic and then waits until the output register frees up.
// Reset loads the register defaults (step 1, delay 20 ms, position 90), drives
// 90 degrees, clears the ramp and arms the countdown so the first tick fires.
// Cfg port always ready; the user must write registers while idle (unenforced).
`default_nettype none

`include "servo_position_ramp_assert.svh"

module servo_position_ramp
  import spr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Input word.
  input  wire logic                 s_axis_tvalid_i,
  output      logic                 s_axis_tready_o,
  input  wire logic [7:0]           s_axis_tdata_i,   // [7:0] target_angle
  input  wire logic                 s_axis_tuser_i,   // [0] opcode
  // Output word.
  output      logic                 m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [7:0] drive_angle, [8] drive_update, [9] moving, [10] goto_rejected,
  // [15:11] zero
  output      logic [15:0]          m_axis_tdata_o,
  // Configuration writes.
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [DelayW-1:0]    cfg_data_i
);

  // Configuration registers.
  logic [AngleW-1:0] max_step_q;
  logic [DelayW-1:0] inc_delay_q;

  // Ramp state.
  logic [AngleW-1:0] start_q, goal_q;
  logic [AngleW-1:0] present_q;
  logic [AngleW-1:0] inc_total_q, inc_index_q;
  logic [DelayW-1:0] ticks_q;
  logic              active_q;

  // Sequencer and shared divider.
  state_e            state_q, state_d;
  job_e              job_q;
  logic              rejected_q;
  logic [DivW-1:0]   quo_q;
  logic [AngleW-1:0] rem_q;
  logic [AngleW-1:0] div_q;
  logic [DivCntW-1:0] cnt_q;

  // Output register.
  logic              out_vld_q;
  logic [AngleW-1:0] out_angle_q;
  logic              out_upd_q, out_moving_q, out_rej_q;

  logic in_acc, cfg_acc, commit, fire;
  logic is_goto;
  logic [AngleW-1:0] gap, delta_mag, step_eff, total_eff;
  logic [AngleW-1:0] q8, off_mag, off8, point;
  logic [AngleW:0]   shifted, trial;
  logic              fits, goal_below;
  logic [AngleW-1:0] count_total;
  logic              idx_in_range, cnt_clear, div_last;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign is_goto = (s_axis_tuser_i == OP_GOTO);
  assign fire    = (ticks_q <= DelayW'(1));
  assign commit  = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready_i);

  // Distance for the increment count: from the present angle to the target.
  assign gap        = (s_axis_tdata_i >= present_q) ? (s_axis_tdata_i - present_q)
                                                    : (present_q - s_axis_tdata_i);
  assign step_eff   = (max_step_q == '0) ? AngleW'(1) : max_step_q;
  assign total_eff  = (inc_total_q == '0) ? AngleW'(1) : inc_total_q;
  assign goal_below = (goal_q < start_q);
  assign delta_mag  = goal_below ? (start_q - goal_q) : (goal_q - start_q);

  // One restoring division step. The remainder stays below the divisor, so the
  // top bit of the trial subtraction is set exactly when the divisor does not fit.
  assign shifted = {rem_q, quo_q[DivW-1]};
  assign trial   = shifted - {1'b0, div_q};
  assign fits    = !trial[AngleW];

  // Floor of the signed offset: a negative quotient with a remainder rounds
  // one further away from zero.
  assign q8          = quo_q[AngleW-1:0];
  assign off_mag     = q8 + AngleW'(rem_q != '0);
  assign off8        = goal_below ? (AngleW'(0) - off_mag) : q8;
  assign point       = start_q + off8;
  assign count_total = (q8 == '0) ? AngleW'(1) : q8;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_goto) begin
            state_d = active_q ? ST_DONE : ST_DIV;
          end else begin
            state_d = (fire && active_q) ? ST_MUL : ST_DONE;
          end
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Port outputs.
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    cfg_ready_o     = 1'b1;
    m_axis_tvalid_o = out_vld_q;
    m_axis_tdata_o  = {5'b0, out_rej_q, out_moving_q, out_upd_q, out_angle_q};
  end

  // Control state, configuration and ramp registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      job_q         <= JOB_NONE;
      rejected_q    <= 1'b0;
      cnt_q         <= '0;
      max_step_q    <= RST_MAX_STEP;
      inc_delay_q   <= RST_INC_DELAY;
      present_q     <= RST_DEFAULT_POS;
      inc_total_q   <= '0;
      inc_index_q   <= '0;
      ticks_q       <= '0;
      active_q      <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_acc) begin
        unique case (cfg_index_i)
          REG_MAX_STEP:    max_step_q  <= cfg_data_i[AngleW-1:0];
          REG_INC_DELAY:   inc_delay_q <= cfg_data_i;
          REG_DEFAULT_POS: begin
            present_q     <= cfg_data_i[AngleW-1:0];
          end
          default: ;
        endcase
      end

      if (in_acc) begin
        rejected_q <= is_goto && active_q;
        if (is_goto) begin
          job_q <= active_q ? JOB_NONE : JOB_COUNT;
          cnt_q <= '1;
        end else begin
          job_q   <= (fire && active_q) ? JOB_POINT : JOB_NONE;
          ticks_q <= fire ? inc_delay_q : (ticks_q - DelayW'(1));
        end
      end

      if (state_q == ST_MUL) begin
        cnt_q <= '1;
      end else if (state_q == ST_DIV) begin
        cnt_q <= cnt_q - DivCntW'(1);
      end

      if (commit) begin
        out_vld_q <= 1'b1;
        unique case (job_q)
          JOB_COUNT: begin
            inc_total_q <= count_total;
            inc_index_q <= AngleW'(1);
            active_q    <= 1'b1;
          end
          JOB_POINT: begin
            present_q <= point;
            if (inc_index_q >= inc_total_q) begin
              inc_index_q <= '0;
              inc_total_q <= '0;
              active_q    <= 1'b0;
            end else begin
              inc_index_q <= inc_index_q + AngleW'(1);
            end
          end
          default: ;
        endcase
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath payload.
  always_ff @(posedge clk_i) begin
    if (in_acc && is_goto && !active_q) begin
      start_q <= present_q;
      goal_q  <= s_axis_tdata_i;
      quo_q   <= DivW'(gap);
      rem_q   <= '0;
      div_q   <= step_eff;
    end

    if (state_q == ST_MUL) begin
      quo_q <= DivW'(delta_mag) * DivW'(inc_index_q);
      rem_q <= '0;
      div_q <= total_eff;
    end else if (state_q == ST_DIV) begin
      rem_q <= fits ? trial[AngleW-1:0] : shifted[AngleW-1:0];
      quo_q <= {quo_q[DivW-2:0], fits};
    end

    if (commit) begin
      out_rej_q <= rejected_q;
      out_upd_q <= (job_q == JOB_POINT);
      unique case (job_q)
        JOB_COUNT: begin
          out_angle_q  <= present_q;
          out_moving_q <= 1'b1;
        end
        JOB_POINT: begin
          out_angle_q  <= point;
          out_moving_q <= (inc_index_q < inc_total_q);
        end
        default: begin
          out_angle_q  <= present_q;
          out_moving_q <= active_q;
        end
      endcase
    end
  end

  assign idx_in_range = (inc_total_q != '0) && (inc_index_q != '0) &&
                        (inc_index_q <= inc_total_q);
  assign cnt_clear    = (inc_total_q == '0) && (inc_index_q == '0);
  assign div_last     = (state_q == ST_DIV) && (cnt_q == '0);

  // A running ramp always has a valid step position within its count.
  `SPR_ASSERT(a_ramp_bounds, !active_q || idx_in_range, "ramp index out of range")
  // An idle ramp keeps its counters cleared.
  `SPR_ASSERT(a_idle_clear, active_q || cnt_clear, "idle ramp counters not cleared")
  // Every accepted word leaves the sequencer busy in the cycle after it is taken.
  `SPR_ASSERT_NEXT(a_accept_busy, in_acc, state_q != ST_IDLE, "sequencer idle after accept")
  // The last divider step hands over to the result stage.
  `SPR_ASSERT_NEXT(a_div_end, div_last, state_q == ST_DONE, "divider overran")

endmodule

`default_nettype wire
